FILE: sv/frd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Flood relay duplicate filter package
// Shared field widths, result status codes and the controller/datapath
// command and status bundles.
// ============================================================================
package frd_pkg;

    localparam int MSG_ID_W = 32;
    localparam int HOP_W    = 8;
    localparam int STATUS_W = 2;

    // Value of the hop limit register after reset.
    localparam logic [HOP_W-1:0] MAX_HOPS_RESET = 8'd5;

    // Input command codes.
    localparam logic CMD_RECEIVED   = 1'b0;
    localparam logic CMD_ORIGINATED = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_FORWARDED  = 2'd0,
        ST_DUPLICATE  = 2'd1,
        ST_HOP_LIMIT  = 2'd2,
        ST_ORIGINATED = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // input may be accepted this cycle
        logic scan_start;  // begin a table search at entry zero
        logic scan_stop;   // end the table search
        logic record;      // store the held identifier in the table
        logic emit;        // load the result register
        logic dup;         // the result is a duplicate drop
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;     // an input beat is offered
        logic item_orig;    // the held item is a local origination
        logic table_empty;  // nothing recorded yet
        logic scan_done;    // the search has an answer
        logic scan_hit;     // the answer is a match
        logic out_free;     // the result register can take a beat
    } t_dp_stat;

endpackage

FILE: sv/frd_in_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Packet header input channel
// Valid/ready channel carrying one packet header per beat.
// ============================================================================
interface frd_in_if
    import frd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [MSG_ID_W-1:0] msg_id;
    logic [HOP_W-1:0]    hop_cnt;

    modport source (output valid, output cmd, output msg_id, output hop_cnt,
                    input ready);
    modport sink   (input valid, input cmd, input msg_id, input hop_cnt,
                    output ready);
endinterface

FILE: sv/frd_out_if.sv
`timescale 1ns / 1ps
// ============================================================================
// Relay decision output channel
// Valid/ready channel carrying one relay decision per beat.
// ============================================================================
interface frd_out_if
    import frd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                send;
    logic [STATUS_W-1:0] status;
    logic [MSG_ID_W-1:0] out_msg_id;
    logic [HOP_W-1:0]    out_hop_cnt;

    modport source (output valid, output send, output status, output out_msg_id,
                    output out_hop_cnt, input ready);
    modport sink   (input valid, input send, input status, input out_msg_id,
                    input out_hop_cnt, output ready);
endinterface

FILE: sv/frd_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// Duplicate filter controller
// Sequences accept, table search, record and result emission for one header.
// ============================================================================
module frd_ctrl
    import frd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SEARCH,
        S_WRITE,
        S_DUP
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands for the datapath.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.item_orig || i_stat.table_empty) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_stat.scan_done) begin
                    o_cmd.scan_stop = 1'b1;
                    n_state         = i_stat.scan_hit ? S_DUP : S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_stat.out_free) begin
                    o_cmd.record = 1'b1;
                    o_cmd.emit   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DUP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.dup  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/frd_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// Duplicate filter datapath
// Identifier table memory, insert pointer, fill count, search compare,
// hop limit register and the result register.
// ============================================================================
module frd_datapath
    import frd_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [HOP_W-1:0]  i_cfg_wdata,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    frd_in_if.sink            i_in,
    frd_out_if.source         o_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Identifier table; entries below the fill count hold valid identifiers.
    logic [MSG_ID_W-1:0] r_ids [TABLE_DEPTH];
    logic [MSG_ID_W-1:0] r_rd_data;

    logic [AW-1:0]       r_wr_ptr;
    logic [CW-1:0]       r_fill;
    logic [HOP_W-1:0]    r_max_hops;

    // Held input item.
    logic                r_cmd;
    logic [MSG_ID_W-1:0] r_id;
    logic [HOP_W-1:0]    r_hops;

    // Search state.
    logic                r_scan_busy;
    logic [AW-1:0]       r_scan_addr;
    logic                r_rd_vld;
    logic                r_rd_last;
    logic                scan_last;
    logic                scan_hit;

    // Result register.
    logic                r_out_valid;
    logic                r_out_send;
    t_status             r_out_status;
    logic [MSG_ID_W-1:0] r_out_id;
    logic [HOP_W-1:0]    r_out_hops;
    logic                out_free;
    t_status             n_status;

    assign i_in.ready = i_cmd.take;

    assign scan_last = ((CW'(r_scan_addr) + CW'(1)) == r_fill);
    assign scan_hit  = r_rd_vld && (r_rd_data == r_id);
    assign out_free  = !r_out_valid || o_out.ready;

    assign o_stat.in_valid    = i_in.valid;
    assign o_stat.item_orig   = (r_cmd == CMD_ORIGINATED);
    assign o_stat.table_empty = (r_fill == '0);
    assign o_stat.scan_done   = scan_hit || (r_rd_vld && r_rd_last);
    assign o_stat.scan_hit    = scan_hit;
    assign o_stat.out_free    = out_free;

    // Capture the input item on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_cmd.take) begin
            r_cmd  <= i_in.cmd;
            r_id   <= i_in.msg_id;
            r_hops <= i_in.hop_cnt;
        end
    end

    // Hop limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_hops <= MAX_HOPS_RESET;
        end else if (i_cfg_we) begin
            r_max_hops <= i_cfg_wdata;
        end
    end

    // Table memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.record) begin
            r_ids[r_wr_ptr] <= r_id;
        end
        r_rd_data <= r_ids[r_scan_addr];
    end

    // Insert pointer wraps at the table depth; the fill count saturates there.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_fill   <= '0;
        end else if (i_cmd.record) begin
            r_wr_ptr <= (r_wr_ptr == AW'(TABLE_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            if (r_fill != CW'(TABLE_DEPTH)) begin
                r_fill <= r_fill + CW'(1);
            end
        end
    end

    // Search walks the filled entries one read per cycle; the compare
    // trails the read address through the registered read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_busy <= 1'b0;
            r_scan_addr <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
        end else begin
            r_rd_vld  <= r_scan_busy && !i_cmd.scan_stop;
            r_rd_last <= scan_last;
            if (i_cmd.scan_start) begin
                r_scan_busy <= 1'b1;
                r_scan_addr <= '0;
            end else if (i_cmd.scan_stop) begin
                r_scan_busy <= 1'b0;
            end else if (r_scan_busy) begin
                r_scan_addr <= r_scan_addr + AW'(1);
                if (scan_last) begin
                    r_scan_busy <= 1'b0;
                end
            end
        end
    end

    // Decision for the held item.
    always_comb begin
        if (i_cmd.dup) begin
            n_status = ST_DUPLICATE;
        end else if (r_cmd == CMD_ORIGINATED) begin
            n_status = ST_ORIGINATED;
        end else if (r_hops < r_max_hops) begin
            n_status = ST_FORWARDED;
        end else begin
            n_status = ST_HOP_LIMIT;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload; dropped packets carry zero fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= n_status;
            case (n_status)
                ST_ORIGINATED: begin
                    r_out_send <= 1'b1;
                    r_out_id   <= r_id;
                    r_out_hops <= '0;
                end
                ST_FORWARDED: begin
                    r_out_send <= 1'b1;
                    r_out_id   <= r_id;
                    r_out_hops <= r_hops + HOP_W'(1);
                end
                default: begin
                    r_out_send <= 1'b0;
                    r_out_id   <= '0;
                    r_out_hops <= '0;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.send        = r_out_send;
    assign o_out.status      = r_out_status;
    assign o_out.out_msg_id  = r_out_id;
    assign o_out.out_hop_cnt = r_out_hops;

`ifndef ASSERT_OFF
    // A new result never overwrites one that has not been taken.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || o_out.ready))
        else $error("result register overwritten");

    // The fill count never passes the table depth.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH))
        else $error("fill count out of range");

    // Until the table is full the insert pointer tracks the fill count.
    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != CW'(TABLE_DEPTH)) |-> (CW'(r_wr_ptr) == r_fill))
        else $error("insert pointer and fill count disagree");

    // The table is never written while a search is running.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.record |-> !r_scan_busy && !r_rd_vld)
        else $error("table write during search");
`endif

endmodule

FILE: sv/flood_relay_duplicate_filter_core.sv
`timescale 1ns / 1ps
// Sequence: an originated header, or any header while the table is empty, goes from the
// decide state straight to the write state; any other received header first searches the table.
// A match ends the search early and drops the header; a miss records it and emits a result.
// One header at a time: the table search reads one entry per cycle from a single memory
// read port, and no new header is accepted until the result is loaded.
// Reset: synchronous; empties the table (fill count and pointer to zero), sets the hop
// limit to 5 and clears the output channel; table contents are not cleared.
// ============================================================================
// Flood relay duplicate filter
// Drops repeated packet identifiers, applies the hop limit and forwards or
// originates packet headers for a flooding mesh relay.
// ============================================================================
module flood_relay_duplicate_filter_core
    import frd_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [HOP_W-1:0] i_cfg_wdata,
    frd_in_if.sink           i_in,
    frd_out_if.source        o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    frd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Table, compare and result datapath.
    frd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in        (i_in),
        .o_out       (o_out)
    );

endmodule
